// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the LFO top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active-low reset)
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== design/wlci_pkg.sv =====
// ----------------------------------------------------------------------------
// wlci_pkg
// Types, constants and the triangle wavetable for the cubic-interpolating LFO.
// ----------------------------------------------------------------------------
package wlci_pkg;

    // Wavetable geometry (power of two, at most 2^16 entries)
    localparam int TRI_ENTRIES    = 1024;
    localparam int TRI_IDX_W      = $clog2(TRI_ENTRIES);
    localparam int TRI_HALF_W     = TRI_IDX_W - 1;
    localparam int TRI_QTR_DEPTH  = TRI_ENTRIES / 4 + 1;
    localparam int HARMONIC_LIMIT = 31;

    // Field and datapath widths
    localparam int RATE_W    = 20;
    localparam int PHASE_W   = 32;
    localparam int HZ_STEP_W = 21;
    localparam int FRAC_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int SMOOTH_W  = 24;

    localparam logic [HZ_STEP_W-1:0] HZ_STEP_RESET = HZ_STEP_W'(89478);
    localparam int SMOOTH_COEF = 3277;

    // Q30 constants for the table build
    localparam longint TRI_GAIN_Q30 = 64'sd870342340;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint ONE_Q30      = 64'sd1073741824;

    // Quarter-wave table entry: {tie, value}; tie marks a half-LSB rounding tie
    typedef logic [SAMPLE_W:0] tri_entry_t;
    typedef logic [TRI_QTR_DEPTH-1:0][SAMPLE_W:0] tri_qtab_t;

    // Microcode operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_MUL_STEP,
        OP_PHASE,
        OP_ADDR,
        OP_READ,
        OP_COEF,
        OP_MUL_T,
        OP_HORNER,
        OP_INTERP,
        OP_DIFF,
        OP_MUL_SM,
        OP_SMOOTH,
        OP_EMIT
    } op_t;

    // Step-advance conditions
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN,
        COND_OUT
    } cond_t;

    // Horner coefficient selects
    localparam logic [1:0] KSEL_C1 = 2'd1;
    localparam logic [1:0] KSEL_C2 = 2'd2;

    // Control handed from the sequencer to the datapath
    typedef struct packed {
        op_t        op;
        logic [1:0] arg;
        logic       go;
    } ctrl_t;

    // Shift-subtract division, elaboration use only
    function automatic longint udiv_loop(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // Q30 sine of a 32-bit phase, Taylor series to x^11 on one quadrant
    function automatic longint sine_q30(longint p);
        longint quad;
        longint r;
        longint x;
        longint x2;
        longint t;
        quad = p >>> 30;
        r    = p & 64'sh3FFFFFFF;
        if ((quad & 64'sd1) != 0) begin
            r = ONE_Q30 - r;
        end
        x  = (r * HALF_PI_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        t  = ONE_Q30 - x2 / 110;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
        t  = (x * t) >>> 30;
        return (quad >= 2) ? -t : t;
    endfunction

    // First quarter (entries 0 .. N/4) of the band-limited triangle.
    // The wave is even about N/4 and odd about N/2, so this covers the table.
    function automatic tri_qtab_t build_tri_qtab();
        tri_qtab_t tab;
        longint    amp [HARMONIC_LIMIT+1];
        longint    acc;
        longint    a;
        longint    p;
        longint    s;
        longint    mag;
        longint    rnd;
        logic      neg;
        for (int h = 0; h <= HARMONIC_LIMIT; h++) begin
            amp[h] = (h == 0) ? 64'sd0 : udiv_loop(TRI_GAIN_Q30, longint'(h * h));
        end
        for (int i = 0; i < TRI_QTR_DEPTH; i++) begin
            acc = 0;
            for (int h = 1; h <= HARMONIC_LIMIT; h += 2) begin
                a   = (longint'(h) * longint'(i)) % TRI_ENTRIES;
                p   = (a <<< 32) / TRI_ENTRIES;
                s   = sine_q30(p);
                mag = (((s < 0) ? -s : s) * amp[h]) >>> 30;
                neg = (s < 0) != ((h % 4) != 1);
                acc = acc + (neg ? -mag : mag);
            end
            rnd = (acc + 64'sd16384) >>> 15;
            if (rnd > 32767) begin
                rnd = 32767;
            end else if (rnd < -32768) begin
                rnd = -32768;
            end
            tab[i] = {((acc & 64'sh7FFF) == 64'sh4000), rnd[SAMPLE_W-1:0]};
        end
        return tab;
    endfunction

    localparam tri_qtab_t TRI_QTAB = build_tri_qtab();

endpackage

// ===== design/wavetable_lfo_cubic_interp.sv =====
// ----------------------------------------------------------------------------
// wavetable_lfo_cubic_interp
// Wavetable LFO: phase accumulator, Catmull-Rom cubic read of a band-limited
// triangle table, one-pole smoother, halved and saturated Q1.15 output.
// ----------------------------------------------------------------------------
// Processing: a 19-step microcode program takes one input word at a time; it
//   shares one 33x22 multiplier and one table read per step, waits in the idle
//   step for an input word and in the emit step for a free output register.
// A finished word waits in the output register while the next one is taken.
// Reset (synchronous, active low): phase and smoother cleared, step register
//   set to 89478; the table is constant, so no fill pass is needed.
`include "assert_macros.svh"

module wavetable_lfo_cubic_interp import wlci_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [HZ_STEP_W-1:0]        cfg_wr_data,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [RATE_W-1:0]           s_rate_hz,
    input  logic [PHASE_W-1:0]          s_phase_offset,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_lfo_value
);

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int T_W     = 32;
    localparam int V_W     = 34;
    localparam int S_W     = SMOOTH_W + 1;

    localparam logic signed [PROD_W-1:0] RND16  = PROD_W'(32768);
    localparam logic signed [V_W-1:0]    V_MAX  = V_W'(8388607);
    localparam logic signed [V_W-1:0]    V_MIN  = -V_W'(8388608);
    localparam logic signed [S_W-1:0]    S_MAX  = S_W'(8388607);
    localparam logic signed [S_W-1:0]    S_MIN  = -S_W'(8388608);
    localparam logic signed [S_W-1:0]    O_MAX  = S_W'(32767);
    localparam logic signed [S_W-1:0]    O_MIN  = -S_W'(32768);
    localparam logic [TRI_HALF_W-1:0]    QTR_LAST = TRI_HALF_W'(TRI_ENTRIES / 4);

    ctrl_t ctrl;
    logic  out_free;

    // Registers
    logic [HZ_STEP_W-1:0]        hz_step_reg, hz_step_next;
    logic [RATE_W-1:0]           rate_reg, rate_next;
    logic [PHASE_W-1:0]          offs_reg, offs_next;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    logic signed [SMOOTH_W-1:0]  smooth_reg, smooth_next;
    logic [TRI_IDX_W-1:0]        idx_reg, idx_next;
    logic [FRAC_W-1:0]           frac_reg, frac_next;
    logic signed [SAMPLE_W-1:0]  y_reg [4];
    logic signed [SAMPLE_W-1:0]  y_next [4];
    logic signed [T_W-1:0]       t_reg, t_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  lfo_reg, lfo_next;

    // Datapath intermediates
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic [PHASE_W-1:0]          phase_sum;
    logic [TRI_IDX_W-1:0]        rd_addr;
    logic [TRI_HALF_W-1:0]       rd_half_idx;
    logic [TRI_HALF_W-1:0]       rd_qidx;
    tri_entry_t                  rd_entry;
    logic signed [SAMPLE_W:0]    rd_neg;
    logic signed [SAMPLE_W-1:0]  rd_val;
    logic signed [T_W-1:0]       yw0, yw1, yw2, yw3;
    logic signed [T_W-1:0]       k1, k2, k3, k_sel;
    logic signed [V_W-1:0]       v_sum, v_rnd;
    logic signed [S_W-1:0]       s_sum, o_rnd;

    // Sequencer
    wlci_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (ctrl.op == OP_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_lfo_value = lfo_reg;

    // Shared multiplier operand select
    always_comb begin
        unique case (ctrl.op)
            OP_MUL_STEP: begin
                mul_a = $signed({{(MUL_A_W-RATE_W){1'b0}}, rate_reg});
                mul_b = $signed({{(MUL_B_W-HZ_STEP_W){1'b0}}, hz_step_reg});
            end
            OP_MUL_T: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = $signed({{(MUL_B_W-FRAC_W){1'b0}}, frac_reg});
            end
            OP_MUL_SM: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(SMOOTH_COEF);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product rounded by 2^16, half up
    assign prod_rnd  = (prod_reg + RND16) >>> 16;
    assign phase_sum = phase_reg + offs_reg;

    // Table read: fold the full-wave address onto the quarter table
    assign rd_addr     = idx_reg + TRI_IDX_W'(ctrl.arg);
    assign rd_half_idx = rd_addr[TRI_HALF_W-1:0];
    // second quarter mirrors the first: N/2 - k, taken modulo the half span
    assign rd_qidx     = (rd_half_idx <= QTR_LAST) ? rd_half_idx
                                                   : TRI_HALF_W'(TRI_ENTRIES / 2) - rd_half_idx;
    assign rd_entry    = TRI_QTAB[rd_qidx];
    // upper half is the negation; a rounding tie shifts it up by one LSB
    assign rd_neg      = -$signed({rd_entry[SAMPLE_W-1], rd_entry[SAMPLE_W-1:0]})
                         + $signed({{SAMPLE_W{1'b0}}, rd_entry[SAMPLE_W]});
    assign rd_val      = rd_addr[TRI_IDX_W-1] ? rd_neg[SAMPLE_W-1:0]
                                              : rd_entry[SAMPLE_W-1:0];

    // Catmull-Rom coefficients (doubled, scaled by 2^8)
    assign yw0 = T_W'(y_reg[0]);
    assign yw1 = T_W'(y_reg[1]);
    assign yw2 = T_W'(y_reg[2]);
    assign yw3 = T_W'(y_reg[3]);
    assign k1  = (yw2 - yw0) <<< 8;
    assign k2  = ((yw0 <<< 1) - (yw1 + (yw1 <<< 2)) + (yw2 <<< 2) - yw3) <<< 8;
    assign k3  = ((yw3 - yw0) + ((yw1 - yw2) + ((yw1 - yw2) <<< 1))) <<< 8;
    assign k_sel = (ctrl.arg == KSEL_C2) ? k2 : k1;

    // Final Horner term plus y1, rounded to Q2.22
    assign v_sum = (V_W'(y_reg[1]) <<< 9) + prod_rnd[V_W-1:0];
    assign v_rnd = (v_sum + V_W'(2)) >>> 2;

    // Smoother update and output rounding
    assign s_sum = S_W'(smooth_reg) + prod_rnd[S_W-1:0];
    assign o_rnd = (S_W'(smooth_reg) + S_W'(128)) >>> 8;

    // Datapath next-state, one micro-op per step
    always_comb begin
        hz_step_next = cfg_wr_en ? cfg_wr_data : hz_step_reg;
        rate_next    = rate_reg;
        offs_next    = offs_reg;
        phase_next   = phase_reg;
        smooth_next  = smooth_reg;
        idx_next     = idx_reg;
        frac_next    = frac_reg;
        for (int i = 0; i < 4; i++) begin
            y_next[i] = y_reg[i];
        end
        t_next       = t_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_ready;
        lfo_next     = lfo_reg;

        if (ctrl.go) begin
            unique case (ctrl.op)
                OP_IDLE: begin
                    rate_next = s_rate_hz;
                    offs_next = s_phase_offset;
                end
                OP_MUL_STEP, OP_MUL_T, OP_MUL_SM: begin
                    prod_next = mul_a * mul_b;
                end
                OP_PHASE: begin
                    phase_next = phase_reg + prod_rnd[PHASE_W-1:0];
                end
                OP_ADDR: begin
                    idx_next  = phase_sum[PHASE_W-1 -: TRI_IDX_W];
                    frac_next = phase_sum[PHASE_W-1-TRI_IDX_W -: FRAC_W];
                end
                OP_READ: begin
                    y_next[ctrl.arg] = rd_val;
                end
                OP_COEF: begin
                    t_next = k3;
                end
                OP_HORNER: begin
                    t_next = k_sel + prod_rnd[T_W-1:0];
                end
                OP_INTERP: begin
                    if (v_rnd > V_MAX) begin
                        t_next = T_W'(V_MAX);
                    end else if (v_rnd < V_MIN) begin
                        t_next = T_W'(V_MIN);
                    end else begin
                        t_next = T_W'(v_rnd);
                    end
                end
                OP_DIFF: begin
                    t_next = t_reg - T_W'(smooth_reg);
                end
                OP_SMOOTH: begin
                    if (s_sum > S_MAX) begin
                        smooth_next = SMOOTH_W'(S_MAX);
                    end else if (s_sum < S_MIN) begin
                        smooth_next = SMOOTH_W'(S_MIN);
                    end else begin
                        smooth_next = SMOOTH_W'(s_sum);
                    end
                end
                OP_EMIT: begin
                    m_valid_next = 1'b1;
                    if (o_rnd > O_MAX) begin
                        lfo_next = SAMPLE_W'(O_MAX);
                    end else if (o_rnd < O_MIN) begin
                        lfo_next = SAMPLE_W'(O_MIN);
                    end else begin
                        lfo_next = SAMPLE_W'(o_rnd);
                    end
                end
                default: begin
                    t_next = t_reg;
                end
            endcase
        end
    end

    // Control state and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hz_step_reg <= HZ_STEP_RESET;
            phase_reg   <= '0;
            smooth_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hz_step_reg <= hz_step_next;
            phase_reg   <= phase_next;
            smooth_reg  <= smooth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rate_reg <= rate_next;
        offs_reg <= offs_next;
        idx_reg  <= idx_next;
        frac_reg <= frac_next;
        for (int i = 0; i < 4; i++) begin
            y_reg[i] <= y_next[i];
        end
        t_reg    <= t_next;
        prod_reg <= prod_next;
        lfo_reg  <= lfo_next;
    end

    // Assertions
    `ASSERT_CLK(a_one_word_in_flight, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "second word taken while one is in flight")
    `ASSERT_CLK(a_emit_sets_valid, aclk, aresetn, (ctrl.go && ctrl.op == OP_EMIT) |=> m_valid, "emit step did not present a result")
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, m_valid && !m_ready && ctrl.go && ctrl.op == OP_EMIT, "pending result overwritten")

endmodule

// ===== design/wlci_seq.sv =====
// ----------------------------------------------------------------------------
// wlci_seq
// Microcode sequencer: step counter, control store and step-advance conditions.
// ----------------------------------------------------------------------------
module wlci_seq import wlci_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  logic  out_free,
    output ctrl_t ctrl
);

    localparam int PROG_LEN = 19;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef struct packed {
        op_t        op;
        logic [1:0] arg;
        cond_t      cond;
        logic       jmp_zero;
    } uword_t;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            go;

    // Control store
    always_comb begin
        unique case (pc_reg)
            PC_W'(0):  uw = '{OP_IDLE,     2'd0,    COND_IN,     1'b0};
            PC_W'(1):  uw = '{OP_MUL_STEP, 2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(2):  uw = '{OP_PHASE,    2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(3):  uw = '{OP_ADDR,     2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(4):  uw = '{OP_READ,     2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(5):  uw = '{OP_READ,     2'd1,    COND_ALWAYS, 1'b0};
            PC_W'(6):  uw = '{OP_READ,     2'd2,    COND_ALWAYS, 1'b0};
            PC_W'(7):  uw = '{OP_READ,     2'd3,    COND_ALWAYS, 1'b0};
            PC_W'(8):  uw = '{OP_COEF,     2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(9):  uw = '{OP_MUL_T,    2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(10): uw = '{OP_HORNER,   KSEL_C2, COND_ALWAYS, 1'b0};
            PC_W'(11): uw = '{OP_MUL_T,    2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(12): uw = '{OP_HORNER,   KSEL_C1, COND_ALWAYS, 1'b0};
            PC_W'(13): uw = '{OP_MUL_T,    2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(14): uw = '{OP_INTERP,   2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(15): uw = '{OP_DIFF,     2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(16): uw = '{OP_MUL_SM,   2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(17): uw = '{OP_SMOOTH,   2'd0,    COND_ALWAYS, 1'b0};
            PC_W'(18): uw = '{OP_EMIT,     2'd0,    COND_OUT,    1'b1};
            default:   uw = '{OP_IDLE,     2'd0,    COND_ALWAYS, 1'b1};
        endcase
    end

    // Step advance condition
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS: go = 1'b1;
            COND_IN:     go = in_valid;
            COND_OUT:    go = out_free;
            default:     go = 1'b0;
        endcase
    end

    // Next step: hold, advance, or jump back to the start
    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            pc_next = uw.jmp_zero ? '0 : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = '{op: uw.op, arg: uw.arg, go: go};

endmodule

// ===== sim/tb_wavetable_lfo_cubic_interp.sv =====
// ============================================================================
// tb_wavetable_lfo_cubic_interp
// Self-checking bench for the cubic-interpolating wavetable LFO. A bit-exact
// predictor (its own triangle table, phase accumulator, Catmull-Rom read and
// one-pole smoother) runs beside the block, and every output word is compared
// with the oldest prediction. A short directed table comes first, then random
// bursts under several step-register settings and handshake idling patterns.
// ============================================================================
module tb_wavetable_lfo_cubic_interp import wlci_pkg::*; ();

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int PIPE_DRAIN    = 24;      // settle time after the last result
    localparam int QUIET_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int WORDS_PER_RUN = 123;
    localparam int TX_IDLE_A     = 34;
    localparam int RX_IDLE_A     = 48;

    // Triangle table geometry and Q30 build constants
    localparam int     TAB_LEN          = 1024;
    localparam int     TAB_IDX_W        = $clog2(TAB_LEN);
    localparam int     FRAC_LO_W        = PHASE_W - TAB_IDX_W;
    localparam int     HARM_TOP         = 31;
    localparam longint GAIN_Q30         = 64'sd870342340;
    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint UNITY_Q30        = 64'sd1073741824;
    localparam longint SMOOTH_K         = 64'sd3277;
    localparam longint S24_HI           = 64'sd8388607;
    localparam longint S24_LO           = -64'sd8388608;
    localparam longint S16_HI           = 64'sd32767;
    localparam longint S16_LO           = -64'sd32768;

    typedef enum logic [1:0] {
        RUN_STEADY,
        RUN_NOISE,
        RUN_SCAN,
        RUN_EDGE
    } run_kind_t;

    // Directed word: known marks a typed-in result, else the predictor decides
    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic [PHASE_W-1:0]  offs;
        logic                known;
        logic [SAMPLE_W-1:0] lfo;
    } lfo_row_t;

    localparam int N_ROWS = 20;
    localparam lfo_row_t LFO_ROWS [N_ROWS] = '{
        // smoother at rest, interpolation lands on the zero crossings
        '{20'h00000, 32'hFFC0_0000, 1'b1, 16'h0000},
        '{20'h00000, 32'h7FC0_0000, 1'b1, 16'h0000},
        // still phase, start of table and the positive peak
        '{20'h00000, 32'h0000_0000, 1'b0, 16'h0000},
        '{20'h00000, 32'h3FC0_0000, 1'b0, 16'h0000},
        '{20'h00000, 32'h3FC0_0000, 1'b0, 16'h0000},
        '{20'h00000, 32'h3FC0_0000, 1'b0, 16'h0000},
        '{20'h00000, 32'h3FFF_FFFF, 1'b0, 16'h0000},
        // neighbors wrap past the table end
        '{20'h00000, 32'hFF40_0000, 1'b0, 16'h0000},
        '{20'h00000, 32'hFF80_8000, 1'b0, 16'h0000},
        '{20'h00000, 32'hFFFF_FFFF, 1'b0, 16'h0000},
        // rate extremes
        '{20'hFFFFF, 32'h0000_0000, 1'b0, 16'h0000},
        '{20'hFFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0000},
        '{20'h00001, 32'h8000_0000, 1'b0, 16'h0000},
        '{20'h80000, 32'h0020_0000, 1'b0, 16'h0000},
        // trough offset and thirds of a turn, on an advancing phase
        '{20'h10000, 32'hC000_0000, 1'b0, 16'h0000},
        '{20'h10000, 32'hC000_0000, 1'b0, 16'h0000},
        '{20'h7FFFF, 32'h5555_5555, 1'b0, 16'h0000},
        '{20'h00001, 32'hAAAA_AAAA, 1'b0, 16'h0000},
        // offset bits below and at the fraction LSB
        '{20'hFFFFF, 32'h0000_003F, 1'b0, 16'h0000},
        '{20'h00000, 32'h0000_0040, 1'b0, 16'h0000}
    };

    logic                        aclk           = 1'b0;
    logic                        aresetn        = 1'b0;
    logic                        cfg_wr_en      = 1'b0;
    logic [HZ_STEP_W-1:0]        cfg_wr_data    = '0;
    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic [RATE_W-1:0]           s_rate_hz      = '0;
    logic [PHASE_W-1:0]          s_phase_offset = '0;
    logic                        m_valid;
    logic                        m_ready        = 1'b0;
    logic signed [SAMPLE_W-1:0]  m_lfo_value;

    // Predictor state
    longint                      tri_wave [TAB_LEN];
    logic [PHASE_W-1:0]          lfo_phase;
    longint                      lfo_smooth;
    logic [HZ_STEP_W-1:0]        step_per_hz;
    logic signed [SAMPLE_W-1:0]  lfo_expected [$];
    logic signed [SAMPLE_W-1:0]  lfo_want;

    int tx_idle_pct   = TX_IDLE_A;
    int rx_idle_pct   = RX_IDLE_A;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int mismatches    = 0;

    wavetable_lfo_cubic_interp DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rate_hz      (s_rate_hz),
        .s_phase_offset (s_phase_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lfo_value    (m_lfo_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Round half up (towards +inf on ties) by an arithmetic shift
    function automatic longint rnd_shift(input longint x, input int sh);
        return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Q30 sine of a full-turn phase, Taylor series to x^11 on one quadrant
    function automatic longint taylor_sine(input logic [PHASE_W-1:0] ph);
        longint r;
        longint x;
        longint x2;
        longint t;
        r = longint'(ph[PHASE_W-3:0]);
        if (ph[PHASE_W-2]) begin
            r = UNITY_Q30 - r;
        end
        x  = (r * QUARTER_TURN_Q30) >>> 30;
        x2 = (x * x) >>> 30;
        t  = UNITY_Q30 - x2 / 110;
        t  = UNITY_Q30 - ((x2 * t) >>> 30) / 72;
        t  = UNITY_Q30 - ((x2 * t) >>> 30) / 42;
        t  = UNITY_Q30 - ((x2 * t) >>> 30) / 20;
        t  = UNITY_Q30 - ((x2 * t) >>> 30) / 6;
        t  = (x * t) >>> 30;
        return ph[PHASE_W-1] ? -t : t;
    endfunction

    // Advance phase and smoother by one word, return the expected sample
    function automatic logic signed [SAMPLE_W-1:0] advance_lfo(
            input logic [RATE_W-1:0] rate, input logic [PHASE_W-1:0] offs);
        longint                adv;
        longint                f;
        longint                y0;
        longint                y1;
        longint                y2;
        longint                y3;
        longint                k1;
        longint                k2;
        longint                k3;
        longint                acc;
        longint                v;
        longint                s;
        logic [PHASE_W-1:0]    p;
        logic [TAB_IDX_W-1:0]  i0;
        logic [TAB_IDX_W-1:0]  i1;
        logic [TAB_IDX_W-1:0]  i2;
        logic [TAB_IDX_W-1:0]  i3;
        adv       = (longint'(rate) * longint'(step_per_hz) + 64'sd32768) >>> 16;
        lfo_phase = lfo_phase + adv[PHASE_W-1:0];
        p         = lfo_phase + offs;
        i0        = p[PHASE_W-1 -: TAB_IDX_W];
        i1        = i0 + 1'b1;
        i2        = i0 + 2'd2;
        i3        = i0 + 2'd3;
        f         = longint'(p[FRAC_LO_W-1 -: FRAC_W]);
        y0        = tri_wave[i0];
        y1        = tri_wave[i1];
        y2        = tri_wave[i2];
        y3        = tri_wave[i3];

        // doubled Catmull-Rom coefficients, scaled by 2^8
        k1 = (y2 - y0) * 256;
        k2 = (2 * y0 - 5 * y1 + 4 * y2 - y3) * 256;
        k3 = ((y3 - y0) + 3 * (y1 - y2)) * 256;

        // Horner evaluation from y1 towards y2
        acc = k3;
        acc = k2 + rnd_shift(acc * f, 16);
        acc = k1 + rnd_shift(acc * f, 16);
        v   = 512 * y1 + rnd_shift(acc * f, 16);
        v   = clamp(rnd_shift(v, 2), S24_LO, S24_HI);

        // one-pole smoother, then halve to Q1.15
        s          = clamp(lfo_smooth + rnd_shift((v - lfo_smooth) * SMOOTH_K, 16),
                           S24_LO, S24_HI);
        lfo_smooth = s;
        s          = clamp(rnd_shift(s, 8), S16_LO, S16_HI);
        return s[SAMPLE_W-1:0];
    endfunction

    // Offer one word, wait for acceptance, queue its expected sample
    task automatic send_word(input logic [RATE_W-1:0] rate, input logic [PHASE_W-1:0] offs,
                             input logic known, input logic signed [SAMPLE_W-1:0] typed);
        logic signed [SAMPLE_W-1:0] pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_rate_hz      <= rate;
        s_phase_offset <= offs;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        pred = advance_lfo(rate, offs);
        lfo_expected.push_back(known ? typed : pred);
    endtask

    // Wait until every pending word is out, then let the pipe settle
    task automatic wait_quiet();
        for (int n = 0; n < QUIET_LIMIT && lfo_expected.size() != 0; n++) begin
            @(posedge aclk);
        end
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    // Load the step register, then random bursts of words
    task automatic run_phase(input logic [HZ_STEP_W-1:0] step_val);
        int                  sent;
        int                  len;
        int                  pick;
        run_kind_t           kind;
        logic [RATE_W-1:0]   rate;
        logic [PHASE_W-1:0]  offs;
        logic [PHASE_W-1:0]  delta;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= step_val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        step_per_hz  = step_val;
        sent         = 0;
        while (sent < WORDS_PER_RUN) begin
            len   = $urandom_range(40, 1);
            pick  = $urandom_range(9);
            kind  = (pick < 4) ? RUN_STEADY : (pick < 6) ? RUN_NOISE :
                    (pick < 8) ? RUN_SCAN : RUN_EDGE;
            rate  = RATE_W'($urandom) >> $urandom_range(16, 0);
            offs  = $urandom;
            delta = $urandom_range(32'h0100_0000);
            for (int k = 0; k < len && sent < WORDS_PER_RUN; k++) begin
                case (kind)
                    RUN_NOISE: begin
                        rate = RATE_W'($urandom);
                        offs = $urandom;
                    end
                    RUN_SCAN: begin
                        offs = offs + delta;
                    end
                    RUN_EDGE: begin
                        rate = ($urandom_range(1) != 0) ? '1 : RATE_W'($urandom_range(1));
                        offs = {TAB_IDX_W'($urandom_range(TAB_LEN - 1, TAB_LEN - 3)),
                                FRAC_LO_W'($urandom)};
                    end
                    default: begin
                    end
                endcase
                send_word(rate, offs, 1'b0, '0);
                sent++;
            end
        end
        s_valid <= 1'b0;
        wait_quiet();
    endtask

    // Result check and receiver ready, with long hold-offs on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lfo_expected.size() == 0) begin
                $error("lfo_value: got %0d with no word pending", m_lfo_value);
                mismatches++;
            end else begin
                lfo_want = lfo_expected.pop_front();
                if (m_lfo_value !== lfo_want) begin
                    $error("lfo_value: expected %0d, got %0d", lfo_want, m_lfo_value);
                    mismatches++;
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        longint              acc;
        longint              s;
        longint              mag;
        logic [PHASE_W-1:0]  ph;
        logic                neg;

        // band-limited triangle: odd harmonics, alternating sign
        for (int i = 0; i < TAB_LEN; i++) begin
            acc = 0;
            for (int h = 1; h <= HARM_TOP; h += 2) begin
                ph  = PHASE_W'((h * i) % TAB_LEN) << FRAC_LO_W;
                s   = taylor_sine(ph);
                mag = (((s < 0) ? -s : s) * (GAIN_Q30 / longint'(h * h))) >>> 30;
                neg = (s < 0) != ((h % 4) != 1);
                acc = neg ? acc - mag : acc + mag;
            end
            tri_wave[i] = clamp(rnd_shift(acc, 15), S16_LO, S16_HI);
        end
        lfo_phase   = '0;
        lfo_smooth  = 0;
        step_per_hz = HZ_STEP_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at the reset step value
        for (int r = 0; r < N_ROWS; r++) begin
            send_word(LFO_ROWS[r].rate, LFO_ROWS[r].offs, LFO_ROWS[r].known, LFO_ROWS[r].lfo);
        end
        s_valid <= 1'b0;
        wait_quiet();

        // sender idles less than receiver
        run_phase(21'd1);
        hold_requests++;
        run_phase(21'd1048576);
        run_phase(21'd0);

        // roles swapped
        tx_idle_pct = RX_IDLE_A;
        rx_idle_pct = TX_IDLE_A;
        run_phase(21'h1F_FFFF);
        hold_requests++;
        run_phase(HZ_STEP_RESET);
        run_phase(HZ_STEP_W'($urandom_range(1048576, 1)));

        // back to back on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(21'd97392);
        run_phase(HZ_STEP_W'($urandom_range(1048576, 1)));
        run_phase(21'd1048576);

        if (lfo_expected.size() != 0) begin
            $error("lfo_value: %0d expected words never arrived", lfo_expected.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
